[sv/fwq_pkg.sv]
// shared types and constants for the fifo wait queue
package fwq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TID_W       = 4;
    localparam int OP_W        = 2;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int PTR_W       = $clog2(MAX_THREADS + 1);
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(MAX_THREADS);
    localparam logic [PTR_W-1:0] CNT_LAST = PTR_W'(MAX_THREADS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_BLOCK    = 2'd0,
        OP_WAKE_ONE = 2'd1,
        OP_WAKE_ALL = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LINK_TAIL,
        ST_READ,
        ST_STEP,
        ST_RM_FIN,
        ST_EMIT_EMPTY,
        ST_EMIT_REFUSED
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic blk_self;
        logic blk_link;
        logic walk_init;
        logic rd_cur;
        logic wake_pop;
        logic all_pop;
        logic rm_adv;
        logic rm_unlink;
        logic rm_fin;
        logic emit_empty;
        logic emit_refused;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
        logic tid_waiting;
        logic head_empty;
        logic cur_empty;
        logic cur_is_tid;
        logic cnt_done;
        logic all_final;
        logic out_free;
    } status_t;

endpackage

[sv/fwq_ram.sv]
// generic single write port ram with registered read
module fwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/fwq_ctrl.sv]
// controller state machine for the fifo wait queue
module fwq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_accept,
    input  fwq_pkg::status_t status,
    output fwq_pkg::cmd_t    cmd
);

    fwq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fwq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fwq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = fwq_pkg::ST_DISPATCH;
                end
            end
            fwq_pkg::ST_DISPATCH: begin
                unique case (status.op)
                    fwq_pkg::OP_BLOCK: begin
                        if (!status.in_range) begin
                            state_next = fwq_pkg::ST_EMIT_EMPTY;
                        end else if (status.tid_waiting) begin
                            state_next = fwq_pkg::ST_EMIT_REFUSED;
                        end else begin
                            state_next = fwq_pkg::ST_LINK_TAIL;
                        end
                    end
                    fwq_pkg::OP_WAKE_ONE, fwq_pkg::OP_WAKE_ALL: begin
                        if (status.head_empty) begin
                            state_next = fwq_pkg::ST_EMIT_EMPTY;
                        end else begin
                            state_next = fwq_pkg::ST_READ;
                        end
                    end
                    fwq_pkg::OP_REMOVE: begin
                        if (!status.in_range || !status.tid_waiting) begin
                            state_next = fwq_pkg::ST_EMIT_EMPTY;
                        end else begin
                            state_next = fwq_pkg::ST_READ;
                        end
                    end
                    default: state_next = fwq_pkg::ST_IDLE;
                endcase
            end
            fwq_pkg::ST_READ: begin
                if (status.op == fwq_pkg::OP_REMOVE && (status.cur_empty || status.cnt_done)) begin
                    state_next = fwq_pkg::ST_RM_FIN;
                end else begin
                    state_next = fwq_pkg::ST_STEP;
                end
            end
            fwq_pkg::ST_STEP: begin
                unique case (status.op)
                    fwq_pkg::OP_WAKE_ONE: begin
                        if (status.out_free) begin
                            state_next = fwq_pkg::ST_IDLE;
                        end
                    end
                    fwq_pkg::OP_WAKE_ALL: begin
                        if (status.out_free) begin
                            state_next = status.all_final ? fwq_pkg::ST_IDLE : fwq_pkg::ST_READ;
                        end
                    end
                    fwq_pkg::OP_REMOVE: begin
                        state_next = status.cur_is_tid ? fwq_pkg::ST_RM_FIN : fwq_pkg::ST_READ;
                    end
                    default: state_next = fwq_pkg::ST_IDLE;
                endcase
            end
            fwq_pkg::ST_LINK_TAIL, fwq_pkg::ST_RM_FIN,
            fwq_pkg::ST_EMIT_EMPTY, fwq_pkg::ST_EMIT_REFUSED: begin
                if (status.out_free) begin
                    state_next = fwq_pkg::ST_IDLE;
                end
            end
            default: state_next = fwq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            fwq_pkg::ST_IDLE: begin
                cmd.in_ready = 1'b1;
            end
            fwq_pkg::ST_DISPATCH: begin
                cmd.walk_init = 1'b1;
                cmd.blk_self  = (status.op == fwq_pkg::OP_BLOCK) && status.in_range
                                && !status.tid_waiting;
            end
            fwq_pkg::ST_READ: begin
                cmd.rd_cur = 1'b1;
            end
            fwq_pkg::ST_STEP: begin
                cmd.wake_pop  = (status.op == fwq_pkg::OP_WAKE_ONE) && status.out_free;
                cmd.all_pop   = (status.op == fwq_pkg::OP_WAKE_ALL) && status.out_free;
                cmd.rm_unlink = (status.op == fwq_pkg::OP_REMOVE) && status.cur_is_tid;
                cmd.rm_adv    = (status.op == fwq_pkg::OP_REMOVE) && !status.cur_is_tid;
            end
            fwq_pkg::ST_LINK_TAIL:    cmd.blk_link     = status.out_free;
            fwq_pkg::ST_RM_FIN:       cmd.rm_fin       = status.out_free;
            fwq_pkg::ST_EMIT_EMPTY:   cmd.emit_empty   = status.out_free;
            fwq_pkg::ST_EMIT_REFUSED: cmd.emit_refused = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[sv/fwq_datapath.sv]
// queue registers, link memory and result register
module fwq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_accept,
    input  logic [fwq_pkg::OP_W-1:0]        in_opcode,
    input  logic [fwq_pkg::TID_W-1:0]       in_thread_id,
    input  fwq_pkg::cmd_t                   cmd,
    output fwq_pkg::status_t                status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fwq_pkg::TID_W-1:0]       out_woken_id,
    output logic                            out_woken_valid,
    output logic                            out_last,
    output logic                            out_refused
);

    fwq_pkg::op_t                 op_reg;
    logic [fwq_pkg::TID_W-1:0]    tid_reg;
    logic [fwq_pkg::PTR_W-1:0]    head_reg, head_next;
    logic [fwq_pkg::PTR_W-1:0]    tail_reg, tail_next;
    logic [fwq_pkg::PTR_W-1:0]    cur_reg, cur_next;
    logic [fwq_pkg::PTR_W-1:0]    prev_reg, prev_next;
    logic [fwq_pkg::PTR_W-1:0]    cnt_reg, cnt_next;
    logic [fwq_pkg::MAX_THREADS-1:0] waiting_reg, waiting_next;

    logic                         out_valid_reg, out_valid_next;
    logic [fwq_pkg::TID_W-1:0]    out_id_reg, out_id_next;
    logic                         out_wv_reg, out_wv_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_ref_reg, out_ref_next;

    logic                         ram_we;
    logic [fwq_pkg::IDX_W-1:0]    ram_waddr;
    logic [fwq_pkg::PTR_W-1:0]    ram_wdata;
    logic [fwq_pkg::PTR_W-1:0]    ram_rdata;

    logic [fwq_pkg::PTR_W-1:0]    tid_ptr;
    logic [fwq_pkg::IDX_W-1:0]    tid_idx;
    logic [fwq_pkg::IDX_W-1:0]    cur_idx;
    logic [fwq_pkg::IDX_W-1:0]    prev_idx;
    logic [fwq_pkg::IDX_W-1:0]    tail_idx;
    logic [fwq_pkg::PTR_W-1:0]    nx;
    logic                         in_range;
    logic                         out_free;
    logic                         all_final;

    assign tid_ptr  = fwq_pkg::PTR_W'(tid_reg);
    assign tid_idx  = fwq_pkg::IDX_W'(tid_reg);
    assign cur_idx  = cur_reg[fwq_pkg::IDX_W-1:0];
    assign prev_idx = prev_reg[fwq_pkg::IDX_W-1:0];
    assign tail_idx = tail_reg[fwq_pkg::IDX_W-1:0];
    assign in_range = 32'(tid_reg) < 32'(fwq_pkg::MAX_THREADS);
    assign nx       = (ram_rdata >= fwq_pkg::PTR_NULL) ? fwq_pkg::PTR_NULL : ram_rdata;
    assign out_free = !out_valid_reg || out_ready;
    assign all_final = (nx == fwq_pkg::PTR_NULL) || (cnt_reg == fwq_pkg::CNT_LAST);

    assign status.op          = op_reg;
    assign status.in_range    = in_range;
    assign status.tid_waiting = in_range && waiting_reg[tid_idx];
    assign status.head_empty  = (head_reg == fwq_pkg::PTR_NULL);
    assign status.cur_empty   = (cur_reg == fwq_pkg::PTR_NULL);
    assign status.cur_is_tid  = (cur_reg == tid_ptr);
    assign status.cnt_done    = (cnt_reg == fwq_pkg::PTR_NULL);
    assign status.all_final   = all_final;
    assign status.out_free    = out_free;

    fwq_ram #(
        .WIDTH (fwq_pkg::PTR_W),
        .DEPTH (fwq_pkg::MAX_THREADS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_cur),
        .raddr (cur_idx),
        .rdata (ram_rdata)
    );

    // link memory write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_idx;
        ram_wdata = fwq_pkg::PTR_NULL;
        if (cmd.blk_self) begin
            ram_we    = 1'b1;
            ram_waddr = tid_idx;
        end else if (cmd.blk_link) begin
            ram_we    = (tail_reg != fwq_pkg::PTR_NULL);
            ram_waddr = tail_idx;
            ram_wdata = tid_ptr;
        end else if (cmd.wake_pop || cmd.all_pop) begin
            ram_we    = 1'b1;
        end else if (cmd.rm_unlink) begin
            ram_we    = (prev_reg != fwq_pkg::PTR_NULL);
            ram_waddr = prev_idx;
            ram_wdata = nx;
        end else if (cmd.rm_fin) begin
            ram_we    = 1'b1;
            ram_waddr = tid_idx;
        end
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        waiting_next   = waiting_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_id_next    = out_id_reg;
        out_wv_next    = out_wv_reg;
        out_last_next  = out_last_reg;
        out_ref_next   = out_ref_reg;

        if (cmd.walk_init) begin
            cur_next  = head_reg;
            prev_next = fwq_pkg::PTR_NULL;
            cnt_next  = '0;
        end

        if (cmd.blk_self) begin
            waiting_next[tid_idx] = 1'b1;
        end

        if (cmd.blk_link) begin
            if (tail_reg == fwq_pkg::PTR_NULL) begin
                head_next = tid_ptr;
            end
            tail_next = tid_ptr;
        end

        if (cmd.wake_pop) begin
            head_next = nx;
            if (nx == fwq_pkg::PTR_NULL) begin
                tail_next = fwq_pkg::PTR_NULL;
            end
            waiting_next[cur_idx] = 1'b0;
        end

        if (cmd.all_pop) begin
            waiting_next[cur_idx] = 1'b0;
            cur_next = nx;
            cnt_next = cnt_reg + 1'b1;
            if (all_final) begin
                head_next = fwq_pkg::PTR_NULL;
                tail_next = fwq_pkg::PTR_NULL;
            end
        end

        if (cmd.rm_adv) begin
            prev_next = cur_reg;
            cur_next  = nx;
            cnt_next  = cnt_reg + 1'b1;
        end

        if (cmd.rm_unlink) begin
            if (prev_reg == fwq_pkg::PTR_NULL) begin
                head_next = nx;
            end
            if (tail_reg == cur_reg) begin
                tail_next = prev_reg;
            end
        end

        if (cmd.rm_fin) begin
            waiting_next[tid_idx] = 1'b0;
        end

        // result register load
        if (cmd.wake_pop || cmd.all_pop) begin
            out_valid_next = 1'b1;
            out_id_next    = cur_reg[fwq_pkg::TID_W-1:0];
            out_wv_next    = 1'b1;
            out_last_next  = cmd.wake_pop || all_final;
            out_ref_next   = 1'b0;
        end else if (cmd.blk_link || cmd.rm_fin || cmd.emit_empty || cmd.emit_refused) begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_wv_next    = 1'b0;
            out_last_next  = 1'b1;
            out_ref_next   = cmd.emit_refused;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= fwq_pkg::PTR_NULL;
            tail_reg      <= fwq_pkg::PTR_NULL;
            waiting_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            waiting_reg   <= waiting_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= fwq_pkg::op_t'(in_opcode);
            tid_reg <= in_thread_id;
        end
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        out_id_reg   <= out_id_next;
        out_wv_reg   <= out_wv_next;
        out_last_reg <= out_last_next;
        out_ref_reg  <= out_ref_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_woken_id    = out_id_reg;
    assign out_woken_valid = out_wv_reg;
    assign out_last        = out_last_reg;
    assign out_refused     = out_ref_reg;

endmodule

[sv/fifo_wait_queue_with_removal.sv]
// top level of the fifo wait queue with removal
//
// A FIFO wait queue of up to 16 thread ids, kept as a linked list in a
// next-pointer memory with head and tail registers and a waiting bit per
// thread. Each transaction on the s_ side carries an opcode (block, wake one,
// wake all, remove) and a thread id; the queue then sends one or more result
// transactions on the m_ side, the final one marked by m_tlast. One operation
// is worked at a time and the next is taken once the last result has been
// loaded into the output register, which may still be waiting for m_tready.
// The link memory has one registered read port, so each link followed takes a read
// state and then a step state, and any operation may also wait on an output stall.
module fifo_wait_queue_with_removal (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fwq_pkg::S_TDATA_W-1:0]   s_tdata,   // thread_id, zero fill
    input  logic [fwq_pkg::S_TUSER_W-1:0]   s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fwq_pkg::M_TDATA_W-1:0]   m_tdata,   // woken_id, zero fill
    output logic                            m_tlast,
    output logic [fwq_pkg::M_TUSER_W-1:0]   m_tuser    // woken_valid, refused
);

    fwq_pkg::cmd_t    cmd;
    fwq_pkg::status_t status;
    logic             s_accept;
    logic [fwq_pkg::TID_W-1:0] woken_id;
    logic             woken_valid;
    logic             refused;

    assign s_tready = cmd.in_ready;
    assign s_accept = s_tvalid && cmd.in_ready;

    fwq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .status   (status),
        .cmd      (cmd)
    );

    fwq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_accept        (s_accept),
        .in_opcode       (s_tuser[fwq_pkg::OP_W-1:0]),
        .in_thread_id    (s_tdata[fwq_pkg::TID_W-1:0]),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_woken_id    (woken_id),
        .out_woken_valid (woken_valid),
        .out_last        (m_tlast),
        .out_refused     (refused)
    );

    assign m_tdata = fwq_pkg::M_TDATA_W'(woken_id);
    assign m_tuser = {refused, woken_valid};

endmodule

[sv/fwq_checker.sv]
// port checker for the fifo wait queue and its bind
module fwq_port_props (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fwq_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [fwq_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fwq_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tlast,
    input logic [fwq_pkg::M_TUSER_W-1:0]   m_tuser
);

    // one operation at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an operation is in progress");

    // a result with no woken thread is the only and final one, with a zero id
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == '0))
        else $error("empty result not final or id not zero");

    // a refused append never names a thread
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tlast))
        else $error("refused result names a woken thread");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

    // nothing reaches the output while idle after reset without an input
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind fifo_wait_queue_with_removal fwq_port_props u_fwq_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
